/* rtl/smad_pkg.sv */
package smad_pkg;

  localparam int PHASE_W = 32;
  localparam int STEP_W = 32;
  localparam int TAB_BITS = 10;
  localparam int SAMPLE_W = 8;
  localparam int SINE_W = 15;
  localparam int QUARTER = 2 ** (TAB_BITS - 2);
  localparam int ADDR_W = TAB_BITS - 2;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'd1246611823);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_W-1:0] qtab_t [QUARTER];

  // quarter-wave sine by taylor series in q2.30, rounded to unsigned q0.15
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    longint q;
    x = (HALF_PI_Q30 * 64'(r)) >> ADDR_W;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[SINE_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i < QUARTER; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();
  localparam logic [SINE_W-1:0] QTOP = quarter_sine(QUARTER);

endpackage

/* rtl/smad_phase.sv */
module smad_phase (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [smad_pkg::STEP_W-1:0]       cfg_data,
  input  logic                              advance,
  output logic [smad_pkg::TAB_BITS-1:0]     idx
);

  logic [smad_pkg::STEP_W-1:0]  phase_step;
  logic [smad_pkg::PHASE_W-1:0] carrier_phase;
  logic [smad_pkg::PHASE_W-1:0] carrier_phase_next;

  assign carrier_phase_next = carrier_phase + smad_pkg::PHASE_W'(phase_step);
  assign idx = carrier_phase[smad_pkg::PHASE_W-1 -: smad_pkg::TAB_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= smad_pkg::STEP_RESET;
      carrier_phase <= '0;
    end else begin
      if (cfg_we) begin
        phase_step <= cfg_data;
      end
      if (advance) begin
        carrier_phase <= carrier_phase_next;
      end
    end
  end

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(carrier_phase))
    else $error("phase moved without a request");

  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> carrier_phase == $past(carrier_phase_next))
    else $error("phase did not advance by the step");

endmodule

/* rtl/smad_mix.sv */
module smad_mix (
  input  logic [smad_pkg::SAMPLE_W-1:0] sample,
  input  logic [smad_pkg::TAB_BITS-1:0] idx,
  output logic [smad_pkg::SAMPLE_W-1:0] mixed
);

  localparam int PROD_W = smad_pkg::SAMPLE_W + smad_pkg::SINE_W;

  logic [1:0]                      quad;
  logic [smad_pkg::ADDR_W-1:0]     r;
  logic [smad_pkg::ADDR_W-1:0]     addr;
  logic [smad_pkg::SINE_W-1:0]     sine_mag;
  logic [smad_pkg::SAMPLE_W-1:0]   cmag;
  logic                            neg;
  logic [PROD_W-1:0]               prod;
  logic [smad_pkg::SAMPLE_W-1:0]   m;
  logic [smad_pkg::SAMPLE_W-1:0]   mid;

  assign quad = idx[smad_pkg::TAB_BITS-1 -: 2];
  assign r    = idx[smad_pkg::ADDR_W-1:0];
  // mirrored quadrants read the table backwards
  assign addr = quad[0] ? (~r + 1'b1) : r;

  always_comb begin
    if (quad[0] && (r == '0)) begin
      sine_mag = smad_pkg::QTOP;
    end else begin
      sine_mag = smad_pkg::QTAB[addr];
    end
  end

  assign mid  = smad_pkg::SAMPLE_W'(1) << (smad_pkg::SAMPLE_W - 1);
  assign cmag = sample[smad_pkg::SAMPLE_W-1] ? (sample - mid) : (mid - sample);
  assign neg  = ~sample[smad_pkg::SAMPLE_W-1] ^ quad[1];
  assign prod = PROD_W'(cmag) * PROD_W'(sine_mag);
  // truncation toward zero on the magnitude
  assign m     = prod[PROD_W-1 -: smad_pkg::SAMPLE_W];
  assign mixed = neg ? (mid - m) : (mid + m);

endmodule

/* rtl/sine_mixer_audio_descrambler_top.sv */
// pipeline: an accepted request is registered in the s1 stage, then mixed and registered at the output
// throughput: one request per cycle, in and out, when the output is not stalled
// the carrier phase advances once per accepted request; the sine table is constant logic
// reset: synchronous, clears both pipeline valids, phase to zero, step to its default
module sine_mixer_audio_descrambler_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [smad_pkg::STEP_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [smad_pkg::SAMPLE_W-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [smad_pkg::SAMPLE_W-1:0] sample_out
);

  logic                          s1_valid;
  logic [smad_pkg::SAMPLE_W-1:0] s1_sample;
  logic [smad_pkg::TAB_BITS-1:0] s1_idx;
  logic [smad_pkg::TAB_BITS-1:0] idx;
  logic [smad_pkg::SAMPLE_W-1:0] mixed;
  logic                          s1_adv;
  logic                          in_acc;

  assign s1_adv   = ~out_valid | out_ready;
  assign in_ready = ~s1_valid | s1_adv;
  assign in_acc   = in_valid & in_ready;

  smad_phase u_phase (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .advance  (in_acc),
    .idx      (idx)
  );

  smad_mix u_mix (
    .sample (s1_sample),
    .idx    (s1_idx),
    .mixed  (mixed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
    if (in_acc) begin
      s1_sample <= sample_in;
      s1_idx    <= idx;
    end
    if (s1_adv && s1_valid) begin
      sample_out <= mixed;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_sample) && $stable(s1_idx))
    else $error("stalled input stage lost its request");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a request behind it");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("request taken with the pipeline full");

endmodule
